>>> hdl/kop_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// kop_pkg
// Shared constants, types and tables for the orbital position core.
// ---------------------------------------------------------------------------
package kop_pkg;

    localparam int MAX_NEWTON_STEPS = 16;
    localparam int TRIG_ITERATIONS  = 32;
    localparam int NEWTON_W         = $clog2(MAX_NEWTON_STEPS + 1);
    localparam int TRIG_W           = $clog2(TRIG_ITERATIONS + 1);
    localparam int CW               = 34;

    localparam logic signed [CW-1:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic [29:0]          RAD_TO_LSB   = 30'd683565276;
    localparam logic [15:0]          TOL_RESET    = 16'd684;
    localparam logic signed [63:0]   POS_MAX      = 64'sd281474976710655;
    localparam logic signed [63:0]   POS_MIN      = -64'sd281474976710656;

    typedef struct packed {
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic               sh_long;
    } ms_req_t;

    function automatic logic [31:0] atan_lsb(input logic [TRIG_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic [48:0] sat49(input logic signed [63:0] v);
        logic [48:0] r;
        if (v > POS_MAX)
        begin
            r = POS_MAX[48:0];
        end
        else if (v < POS_MIN)
        begin
            r = POS_MIN[48:0];
        end
        else
        begin
            r = v[48:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/kop_cordic.sv
`default_nettype none
// ---------------------------------------------------------------------------
// kop_cordic
// Iterative rotation-mode CORDIC giving Q30 cosine and sine of a binary angle.
// ---------------------------------------------------------------------------
module kop_cordic (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [31:0]                   angle,
    output logic                               busy,
    output logic                               done,
    output logic signed [kop_pkg::CW-1:0]      cos_val,
    output logic signed [kop_pkg::CW-1:0]      sin_val
);

    logic signed [kop_pkg::CW-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic signed [kop_pkg::CW-1:0] cos_reg, cos_next, sin_reg, sin_next;
    logic [kop_pkg::TRIG_W-1:0]    cnt_reg, cnt_next;
    logic                          flip_reg, flip_next;
    logic                          busy_reg, busy_next, done_reg, done_next;
    logic signed [kop_pkg::CW-1:0] z0, dx, dy, at, x_upd, y_upd, z_upd;
    logic [31:0]                   ang_red;
    logic                          wide;

    always_comb
    begin
        z0      = {{(kop_pkg::CW-32){angle[31]}}, angle};
        wide    = (z0 > kop_pkg::QUARTER_TURN) || (z0 < -kop_pkg::QUARTER_TURN);
        ang_red = wide ? angle + 32'h8000_0000 : angle;
        dx      = y_reg >>> cnt_reg;
        dy      = x_reg >>> cnt_reg;
        at      = $signed({{(kop_pkg::CW-32){1'b0}}, kop_pkg::atan_lsb(cnt_reg)});
        if (!z_reg[kop_pkg::CW-1])
        begin
            x_upd = x_reg - dx;
            y_upd = y_reg + dy;
            z_upd = z_reg - at;
        end
        else
        begin
            x_upd = x_reg + dx;
            y_upd = y_reg - dy;
            z_upd = z_reg + at;
        end

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        flip_next = flip_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cos_next  = cos_reg;
        sin_next  = sin_reg;
        if (start)
        begin
            x_next    = kop_pkg::INV_GAIN_Q30;
            y_next    = '0;
            z_next    = {{(kop_pkg::CW-32){ang_red[31]}}, ang_red};
            flip_next = wide;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next   = x_upd;
            y_next   = y_upd;
            z_next   = z_upd;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == kop_pkg::TRIG_W'(kop_pkg::TRIG_ITERATIONS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                cos_next  = flip_reg ? -x_upd : x_upd;
                sin_next  = flip_reg ? -y_upd : y_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule
`default_nettype wire

>>> hdl/kop_divider.sv
`default_nettype none
// ---------------------------------------------------------------------------
// kop_divider
// Restoring divider for the Newton step, num * 2^30 / den, one bit a cycle.
// ---------------------------------------------------------------------------
module kop_divider (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [33:0] num,
    input  wire logic signed [33:0] den,
    output logic                    done,
    output logic signed [63:0]      quot,
    output logic [62:0]             quot_mag
);

    logic [62:0] n_reg, n_next;
    logic [33:0] r_reg, r_next, d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next, busy_reg, busy_next, done_reg, done_next;
    logic [33:0] num_mag, den_mag;
    logic [34:0] r_sh, diff;
    logic        ge;

    always_comb
    begin
        num_mag = num[33] ? 34'(-num) : 34'(num);
        den_mag = den[33] ? 34'(-den) : 34'(den);
        r_sh    = {r_reg, n_reg[62]};
        diff    = r_sh - {1'b0, d_reg};
        ge      = r_sh >= {1'b0, d_reg};

        n_next    = n_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            n_next    = {num_mag[32:0], 30'b0};
            r_next    = '0;
            d_next    = den_mag;
            neg_next  = num[33] ^ den[33];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next   = ge ? diff[33:0] : r_sh[33:0];
            n_next   = {n_reg[61:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 6'd62)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quot_mag = n_reg;
    assign quot     = neg_reg ? -$signed({1'b0, n_reg}) : $signed({1'b0, n_reg});

endmodule
`default_nettype wire

>>> hdl/kop_isqrt.sv
`default_nettype none
// ---------------------------------------------------------------------------
// kop_isqrt
// Digit-by-digit floor square root of a 64-bit value, two bits a cycle.
// ---------------------------------------------------------------------------
module kop_isqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] value,
    output logic             done,
    output logic [31:0]      root
);

    logic [63:0] v_reg, v_next, res_reg, res_next, bit_reg, bit_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [63:0] sum;

    always_comb
    begin
        sum       = res_reg + bit_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            v_next    = value;
            res_next  = '0;
            bit_next  = 64'h4000_0000_0000_0000;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (v_reg >= sum)
            begin
                v_next   = v_reg - sum;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == 64'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule
`default_nettype wire

>>> hdl/kop_mulshift.sv
`default_nettype none
// ---------------------------------------------------------------------------
// kop_mulshift
// 64 by 64 bit scaled product from four 32 by 32 bit partial products,
// rounded half away from zero and capped at 2^62 in magnitude.
// ---------------------------------------------------------------------------
module kop_mulshift (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire kop_pkg::ms_req_t req,
    output logic                  busy,
    output logic                  done,
    output logic signed [63:0]    result
);

    logic [63:0]        ua_reg, ua_next, ub_reg, ub_next;
    logic [127:0]       acc_reg, acc_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               neg_reg, neg_next, long_reg, long_next;
    logic               busy_reg, busy_next, done_reg, done_next;
    logic signed [63:0] res_reg, res_next;
    logic [31:0]        ai, bj;
    logic [63:0]        pp, mag, mag_cap;
    logic [127:0]       pp_sh, acc2;
    logic               over;

    always_comb
    begin
        ai      = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
        bj      = cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
        pp      = ai * bj;
        pp_sh   = {64'b0, pp} << {cnt_reg[1] & cnt_reg[0], cnt_reg[1] ^ cnt_reg[0], 5'b0};
        acc2    = acc_reg + (long_reg ? (128'd1 << 60) : (128'd1 << 29));
        over    = long_reg ? (|acc2[127:123]) : (|acc2[127:92]);
        mag     = long_reg ? acc2[124:61] : acc2[93:30];
        mag_cap = over ? 64'h4000_0000_0000_0000 : mag;

        ua_next   = ua_reg;
        ub_next   = ub_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        long_next = long_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (start)
        begin
            ua_next   = req.a[63] ? 64'(-req.a) : 64'(req.a);
            ub_next   = req.b[63] ? 64'(-req.b) : 64'(req.b);
            neg_next  = req.a[63] ^ req.b[63];
            long_next = req.sh_long;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg[2])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? -$signed(mag_cap) : $signed(mag_cap);
            end
            else
            begin
                acc_next = acc_reg + pp_sh;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ua_reg   <= ua_next;
        ub_reg   <= ub_next;
        acc_reg  <= acc_next;
        neg_reg  <= neg_next;
        long_reg <= long_next;
        res_reg  <= res_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

>>> hdl/kepler_orbit_position_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// kepler_orbit_position_core
// Orbital elements to a cartesian position: Newton solution of Kepler's
// equation, orbital-plane coordinates and three frame rotations.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Content
//  s_axis   in         s_axis_tvalid/tready       one set of orbital elements
//  m_axis   out        m_axis_tvalid/tready       position and status flags
//  cfg      in         cfg_valid/cfg_ready        convergence tolerance
//
// An item takes N Newton steps, N being 1 to 16; each step runs the 32-step
// CORDIC and the serial divider.
// An earth-fixed request skips the solver and goes straight to the output state.
// Reset returns to idle with the tolerance at 684.
// A result waits in the output register while the next request is taken.
// ---------------------------------------------------------------------------
module kepler_orbit_position_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // semi_major_axis, eccentricity_q31, inclination_angle,
    // node_longitude_angle, periapsis_argument_angle, mean_anomaly_angle
    input  wire logic [207:0] s_axis_tdata,
    // frame_code
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // pos_x, pos_y, pos_z
    output logic [151:0]      m_axis_tdata,
    // frame_out, frame_error, not_converged
    output logic [3:0]        m_axis_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data
);

    typedef enum logic [23:0] {
        ST_IDLE    = 24'd1 << 0,
        ST_TRIG_M  = 24'd1 << 1,
        ST_EM0     = 24'd1 << 2,
        ST_EM1     = 24'd1 << 3,
        ST_EM2     = 24'd1 << 4,
        ST_NT_TRIG = 24'd1 << 5,
        ST_NE0     = 24'd1 << 6,
        ST_NE1     = 24'd1 << 7,
        ST_NE2     = 24'd1 << 8,
        ST_NE3     = 24'd1 << 9,
        ST_NDIV    = 24'd1 << 10,
        ST_FT_TRIG = 24'd1 << 11,
        ST_EE      = 24'd1 << 12,
        ST_SQ0     = 24'd1 << 13,
        ST_SQW     = 24'd1 << 14,
        ST_PYM     = 24'd1 << 15,
        ST_PX      = 24'd1 << 16,
        ST_PXW     = 24'd1 << 17,
        ST_PYW     = 24'd1 << 18,
        ST_TP      = 24'd1 << 19,
        ST_TI      = 24'd1 << 20,
        ST_TN      = 24'd1 << 21,
        ST_ROT     = 24'd1 << 22,
        ST_ROTW    = 24'd1 << 23
    } state_t;

    localparam int CW = kop_pkg::CW;

    state_t state_reg, state_next;
    logic [15:0] tol_reg, tol_next;
    logic [1:0]  frame_reg, frame_next;
    logic [46:0] a_reg, a_next;
    logic [30:0] e_reg, e_next;
    logic [31:0] inc_reg, inc_next, node_reg, node_next, peri_reg, peri_next;
    logic [31:0] mean_reg, mean_next, ecc_reg, ecc_next, sq_reg, sq_next;
    logic signed [33:0] f_reg, f_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [kop_pkg::NEWTON_W-1:0] iter_reg, iter_next;
    logic conv_reg, conv_next, fe_reg, fe_next;
    logic signed [CW-1:0] ce_reg, ce_next, se_reg, se_next, co_reg, co_next;
    logic signed [CW-1:0] so_reg, so_next, ci_reg, ci_next, si_reg, si_next;
    logic signed [CW-1:0] cn_reg, cn_next, sn_reg, sn_next;
    logic signed [63:0] px_reg, px_next, py_reg, py_next, t0_reg, t0_next;
    logic signed [63:0] x1_reg, x1_next, y1_reg, y1_next, y2_reg, y2_next;
    logic signed [63:0] z2_reg, z2_next, xf_reg, xf_next, yf_reg, yf_next;
    logic [3:0]  rot_reg, rot_next;
    logic        ov_reg, ov_next;
    logic [151:0] od_reg, od_next;
    logic [3:0]  ou_reg, ou_next;

    logic        cord_start, cord_busy, cord_done;
    logic [31:0] cord_angle;
    logic signed [CW-1:0] cord_cos, cord_sin;
    logic        div_start, div_done;
    logic signed [33:0] div_den;
    logic signed [63:0] div_quot;
    logic [62:0] div_mag;
    logic        sq_start, sq_done;
    logic [31:0] sq_root;
    logic        ms_start, ms_busy, ms_done;
    kop_pkg::ms_req_t ms_req;
    logic signed [63:0] ms_res;

    logic signed [34:0] mul_a, mul_b;
    logic signed [69:0] mul_full;
    logic signed [63:0] rnd, ce_w, px_op, a_w;
    logic signed [33:0] fp;
    logic [31:0] elsb, mdiff;
    logic        s_acc, hit;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        mul_a    = $signed({4'b0, e_reg});
        mul_b    = {{(35-CW){cord_sin[CW-1]}}, cord_sin};
        unique case (state_reg)
            ST_EM1, ST_NE1:
            begin
                mul_a = $signed(prod_reg[63:29]);
                mul_b = $signed({5'b0, kop_pkg::RAD_TO_LSB});
            end
            ST_NE2:  mul_b = {{(35-CW){cord_cos[CW-1]}}, cord_cos};
            ST_EE:   mul_b = $signed({4'b0, e_reg});
            ST_PYM:
            begin
                mul_a = $signed({3'b0, sq_reg});
                mul_b = {{(35-CW){se_reg[CW-1]}}, se_reg};
            end
            default: ;
        endcase
        mul_full = mul_a * mul_b;
        rnd      = prod_reg + 64'sd2147483648;
        elsb     = rnd[63:32];
        mdiff    = mean_reg - ecc_reg;
        fp       = $signed({prod_reg[63], prod_reg[63:31]}) - 34'sd1073741824;
        if (fp > -34'sd1)
        begin
            fp = -34'sd1;
        end
        ce_w     = {{(64-CW){ce_reg[CW-1]}}, ce_reg};
        px_op    = (ce_w <<< 31) - $signed({3'b0, e_reg, 30'b0});
        a_w      = $signed({17'b0, a_reg});
        hit      = div_mag <= {47'b0, tol_reg};
        div_den  = fp;
    end

    always_comb
    begin
        state_next = state_reg;
        tol_next   = tol_reg;
        frame_next = frame_reg;
        a_next     = a_reg;
        e_next     = e_reg;
        inc_next   = inc_reg;
        node_next  = node_reg;
        peri_next  = peri_reg;
        mean_next  = mean_reg;
        ecc_next   = ecc_reg;
        sq_next    = sq_reg;
        f_next     = f_reg;
        prod_next  = prod_reg;
        iter_next  = iter_reg;
        conv_next  = conv_reg;
        fe_next    = fe_reg;
        ce_next    = ce_reg;
        se_next    = se_reg;
        co_next    = co_reg;
        so_next    = so_reg;
        ci_next    = ci_reg;
        si_next    = si_reg;
        cn_next    = cn_reg;
        sn_next    = sn_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        t0_next    = t0_reg;
        x1_next    = x1_reg;
        y1_next    = y1_reg;
        y2_next    = y2_reg;
        z2_next    = z2_reg;
        xf_next    = xf_reg;
        yf_next    = yf_reg;
        rot_next   = rot_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        ou_next    = ou_reg;
        cord_start = 1'b0;
        cord_angle = s_axis_tdata[205:174];
        div_start  = 1'b0;
        sq_start   = 1'b0;
        ms_start   = 1'b0;
        ms_req.a   = a_w;
        ms_req.b   = px_op;
        ms_req.sh_long = 1'b1;

        if (cfg_valid)
        begin
            tol_next = cfg_data;
        end
        if (ov_reg && m_axis_tready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    frame_next = s_axis_tuser;
                    a_next     = s_axis_tdata[46:0];
                    e_next     = s_axis_tdata[77:47];
                    inc_next   = s_axis_tdata[109:78];
                    node_next  = s_axis_tdata[141:110];
                    peri_next  = s_axis_tdata[173:142];
                    mean_next  = s_axis_tdata[205:174];
                    iter_next  = '0;
                    if (s_axis_tuser == 2'd0)
                    begin
                        fe_next    = 1'b1;
                        conv_next  = 1'b1;
                        xf_next    = '0;
                        yf_next    = '0;
                        z2_next    = '0;
                        state_next = ST_ROTW;
                        rot_next   = 4'd15;
                    end
                    else
                    begin
                        fe_next    = 1'b0;
                        conv_next  = 1'b0;
                        cord_start = 1'b1;
                        state_next = ST_TRIG_M;
                    end
                end
            end
            ST_TRIG_M:
            begin
                if (cord_done)
                begin
                    state_next = ST_EM0;
                end
            end
            ST_EM0:
            begin
                prod_next  = mul_full[63:0];
                state_next = ST_EM1;
            end
            ST_EM1:
            begin
                prod_next  = mul_full[63:0];
                state_next = ST_EM2;
            end
            ST_EM2:
            begin
                ecc_next   = mean_reg + elsb;
                cord_start = 1'b1;
                cord_angle = mean_reg + elsb;
                state_next = ST_NT_TRIG;
            end
            ST_NT_TRIG:
            begin
                if (cord_done)
                begin
                    state_next = ST_NE0;
                end
            end
            ST_NE0:
            begin
                prod_next  = mul_full[63:0];
                state_next = ST_NE1;
            end
            ST_NE1:
            begin
                prod_next  = mul_full[63:0];
                state_next = ST_NE2;
            end
            ST_NE2:
            begin
                f_next     = $signed({{2{mdiff[31]}}, mdiff}) + $signed({{2{elsb[31]}}, elsb});
                prod_next  = mul_full[63:0];
                state_next = ST_NE3;
            end
            ST_NE3:
            begin
                div_start  = 1'b1;
                state_next = ST_NDIV;
            end
            ST_NDIV:
            begin
                if (div_done)
                begin
                    ecc_next   = ecc_reg - div_quot[31:0];
                    cord_start = 1'b1;
                    cord_angle = ecc_reg - div_quot[31:0];
                    conv_next  = hit;
                    iter_next  = iter_reg + 1'b1;
                    if (hit || iter_reg ==
                        kop_pkg::NEWTON_W'(kop_pkg::MAX_NEWTON_STEPS - 1))
                    begin
                        state_next = ST_FT_TRIG;
                    end
                    else
                    begin
                        state_next = ST_NT_TRIG;
                    end
                end
            end
            ST_FT_TRIG:
            begin
                if (cord_done)
                begin
                    ce_next    = cord_cos;
                    se_next    = cord_sin;
                    state_next = ST_EE;
                end
            end
            ST_EE:
            begin
                prod_next  = mul_full[63:0];
                state_next = ST_SQ0;
            end
            ST_SQ0:
            begin
                sq_start   = 1'b1;
                state_next = ST_SQW;
            end
            ST_SQW:
            begin
                if (sq_done)
                begin
                    sq_next    = sq_root;
                    state_next = ST_PYM;
                end
            end
            ST_PYM:
            begin
                prod_next  = mul_full[63:0];
                state_next = ST_PX;
            end
            ST_PX:
            begin
                ms_start   = 1'b1;
                state_next = ST_PXW;
            end
            ST_PXW:
            begin
                if (ms_done)
                begin
                    px_next    = ms_res;
                    ms_req.b   = prod_reg;
                    ms_start   = 1'b1;
                    state_next = ST_PYW;
                end
            end
            ST_PYW:
            begin
                if (ms_done)
                begin
                    py_next    = ms_res;
                    cord_start = 1'b1;
                    cord_angle = peri_reg;
                    state_next = ST_TP;
                end
            end
            ST_TP:
            begin
                if (cord_done)
                begin
                    co_next    = cord_cos;
                    so_next    = cord_sin;
                    cord_start = 1'b1;
                    cord_angle = inc_reg;
                    state_next = ST_TI;
                end
            end
            ST_TI:
            begin
                if (cord_done)
                begin
                    ci_next    = cord_cos;
                    si_next    = cord_sin;
                    cord_start = 1'b1;
                    cord_angle = node_reg;
                    state_next = ST_TN;
                end
            end
            ST_TN:
            begin
                if (cord_done)
                begin
                    cn_next    = cord_cos;
                    sn_next    = cord_sin;
                    rot_next   = '0;
                    state_next = ST_ROT;
                end
            end
            ST_ROT:
            begin
                ms_start       = 1'b1;
                ms_req.sh_long = 1'b0;
                unique case (rot_reg)
                    4'd0: begin ms_req.a = px_reg; ms_req.b = 64'(co_reg); end
                    4'd1: begin ms_req.a = py_reg; ms_req.b = 64'(so_reg); end
                    4'd2: begin ms_req.a = px_reg; ms_req.b = 64'(so_reg); end
                    4'd3: begin ms_req.a = py_reg; ms_req.b = 64'(co_reg); end
                    4'd4: begin ms_req.a = y1_reg; ms_req.b = 64'(ci_reg); end
                    4'd5: begin ms_req.a = y1_reg; ms_req.b = 64'(si_reg); end
                    4'd6: begin ms_req.a = x1_reg; ms_req.b = 64'(cn_reg); end
                    4'd7: begin ms_req.a = y2_reg; ms_req.b = 64'(sn_reg); end
                    4'd8: begin ms_req.a = x1_reg; ms_req.b = 64'(sn_reg); end
                    default: begin ms_req.a = y2_reg; ms_req.b = 64'(cn_reg); end
                endcase
                state_next = ST_ROTW;
            end
            ST_ROTW:
            begin
                if (rot_reg == 4'd15 || rot_reg == 4'd10)
                begin
                    if (!ov_reg || m_axis_tready)
                    begin
                        ov_next = 1'b1;
                        od_next = {3'b0, kop_pkg::sat49(z2_reg),
                                   kop_pkg::sat49(yf_reg), kop_pkg::sat49(xf_reg)};
                        ou_next = {!conv_reg, fe_reg, frame_reg};
                        state_next = ST_IDLE;
                    end
                end
                else if (ms_done)
                begin
                    rot_next   = rot_reg + 1'b1;
                    state_next = (rot_reg == 4'd9) ? ST_ROTW : ST_ROT;
                    unique case (rot_reg)
                        4'd0, 4'd2, 4'd6, 4'd8: t0_next = ms_res;
                        4'd1:    x1_next = t0_reg - ms_res;
                        4'd3:    y1_next = t0_reg + ms_res;
                        4'd4:    y2_next = ms_res;
                        4'd5:    z2_next = ms_res;
                        4'd7:    xf_next = t0_reg - ms_res;
                        default: yf_next = t0_reg + ms_res;
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tol_reg   <= kop_pkg::TOL_RESET;
            ov_reg    <= 1'b0;
            iter_reg  <= '0;
            rot_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tol_reg   <= tol_next;
            ov_reg    <= ov_next;
            iter_reg  <= iter_next;
            rot_reg   <= rot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        a_reg     <= a_next;
        e_reg     <= e_next;
        inc_reg   <= inc_next;
        node_reg  <= node_next;
        peri_reg  <= peri_next;
        mean_reg  <= mean_next;
        ecc_reg   <= ecc_next;
        sq_reg    <= sq_next;
        f_reg     <= f_next;
        prod_reg  <= prod_next;
        conv_reg  <= conv_next;
        fe_reg    <= fe_next;
        ce_reg    <= ce_next;
        se_reg    <= se_next;
        co_reg    <= co_next;
        so_reg    <= so_next;
        ci_reg    <= ci_next;
        si_reg    <= si_next;
        cn_reg    <= cn_next;
        sn_reg    <= sn_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        t0_reg    <= t0_next;
        x1_reg    <= x1_next;
        y1_reg    <= y1_next;
        y2_reg    <= y2_next;
        z2_reg    <= z2_next;
        xf_reg    <= xf_next;
        yf_reg    <= yf_next;
        od_reg    <= od_next;
        ou_reg    <= ou_next;
    end

    kop_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cord_start),
        .angle   (cord_angle),
        .busy    (cord_busy),
        .done    (cord_done),
        .cos_val (cord_cos),
        .sin_val (cord_sin)
    );

    kop_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (f_reg),
        .den      (div_den),
        .done     (div_done),
        .quot     (div_quot),
        .quot_mag (div_mag)
    );

    kop_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (64'h4000_0000_0000_0000 - prod_reg),
        .done  (sq_done),
        .root  (sq_root)
    );

    kop_mulshift u_mulshift (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ms_start),
        .req    (ms_req),
        .busy   (ms_busy),
        .done   (ms_done),
        .result (ms_res)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;

    a_frame0_skip: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_axis_tuser == 2'd0 |=> state_reg == ST_ROTW)
        else $error("earth-fixed request did not skip the solver");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata == '0 && !m_axis_tuser[3])
        else $error("rejected request carries a position");

    a_cord_free: assert property (@(posedge clk) disable iff (!rst_n)
        cord_start |-> !cord_busy)
        else $error("CORDIC restarted while busy");

    a_ms_free: assert property (@(posedge clk) disable iff (!rst_n)
        ms_start |-> !ms_busy)
        else $error("multiplier restarted while busy");

endmodule
`default_nettype wire

>>> bench/kepler_orbit_position_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kepler_orbit_position_core_test
// Self-checking bench for the orbital position core. Orbital element
// requests go in over the input stream and positions come back over the
// output stream. Each response is compared field by field against a
// fixed-point model of the Kepler solver and the frame rotations. The run
// steps through several convergence tolerances, the extremes among them,
// with random idling on both sides and one long output stall.
// ---------------------------------------------------------------------------
module kepler_orbit_position_core_test;
    import kop_pkg::*;

    localparam logic [1:0] FRAME_EARTH_FIXED = 2'd0;
    localparam int         STALL_LIMIT       = 20000;
    localparam int         HOLD_CYCLES       = 4000;

    typedef struct {
        logic [1:0]  frame;
        logic [46:0] sma;
        logic [30:0] ecc;
        logic [31:0] incl;
        logic [31:0] node;
        logic [31:0] peri;
        logic [31:0] mean;
    } elements_t;

    typedef struct {
        logic [48:0] x;
        logic [48:0] y;
        logic [48:0] z;
        logic [1:0]  frame;
        logic        frame_err;
        logic        not_conv;
    } position_t;

    typedef struct {
        elements_t el;
        bit        fixed;
    } directed_row_t;

    localparam longint ARC_TABLE [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [207:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [151:0] m_axis_tdata;
    logic [3:0]   m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [15:0]  cfg_data;

    position_t     expected_positions[$];
    directed_row_t directed[$];
    logic [15:0]   tol_model;
    bit            cur_fixed;
    bit            calm;
    bit            hold_request;
    int            hold_left;
    int            errors;
    int            requests_in;
    int            positions_out;
    int            unconverged_seen;
    int            frame_errors_seen;
    int            idle_count;

    kepler_orbit_position_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void cordic(input logic [31:0] ang, output longint c, output longint s);
        logic [31:0] w;
        longint      z;
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        bit          flip;
        w = ang;
        z = longint'($signed(w));
        flip = 1'b0;
        x = 652032874;
        y = 0;
        if (z > 1073741824 || z < -1073741824)
        begin
            w = w + 32'h80000000;
            z = longint'($signed(w));
            flip = 1'b1;
        end
        for (int i = 0; i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARC_TABLE[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARC_TABLE[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint scale_round(input longint a, input longint b, input int sh);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [63:0]  mag;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        p = {64'd0, ua} * {64'd0, ub};
        p = p + (128'd1 << (sh - 1));
        if ((p >> (sh + 62)) != 0)
        begin
            mag = 64'd1 << 62;
        end
        else
        begin
            mag = 64'(p >> sh);
        end
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint ecc_to_angle(input longint e, input longint t);
        longint p;
        p = (e * t) >>> 29;
        return (p * 683565276 + 64'sd2147483648) >>> 32;
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [48:0] clamp49(input longint v);
        longint r;
        r = v > 64'sd281474976710655 ? 64'sd281474976710655 :
            (v < -64'sd281474976710656 ? -64'sd281474976710656 : v);
        return r[48:0];
    endfunction

    function automatic position_t predict_position(input elements_t el, input logic [15:0] tol);
        position_t   r;
        longint      a;
        longint      e;
        longint      c;
        longint      s;
        longint      f;
        longint      fp;
        longint      d;
        longint      px;
        longint      py;
        longint      co;
        longint      so;
        longint      ci;
        longint      si;
        longint      cn;
        longint      sn;
        longint      x1;
        longint      y1;
        longint      y2;
        longint      z2;
        logic [31:0] anom;
        logic [31:0] diff;
        logic [63:0] root;
        bit          done;
        r.frame = el.frame;
        r.x = '0;
        r.y = '0;
        r.z = '0;
        r.not_conv = 1'b0;
        r.frame_err = (el.frame == FRAME_EARTH_FIXED);
        if (r.frame_err)
        begin
            return r;
        end
        a = longint'(el.sma);
        e = longint'(el.ecc);
        cordic(el.mean, c, s);
        anom = el.mean + ecc_to_angle(e, s)
        ;
        done = 1'b0;
        for (int n = 0; n < 16 && !done; n++)
        begin
            cordic(anom, c, s);
            diff = el.mean - anom;
            f = longint'($signed(diff)) + ecc_to_angle(e, s);
            fp = ((e * c) >>> 31) - 1073741824;
            if (fp > -1)
            begin
                fp = -1;
            end
            d = (f * 1073741824) / fp;
            anom = anom - d[31:0];
            if ((d < 0 ? -d : d) <= longint'(tol))
            begin
                done = 1'b1;
            end
        end
        cordic(anom, c, s);
        px = scale_round(a, c * 64'sd2147483648 - e * 1073741824, 61);
        root = root_floor((64'd1 << 62) - 64'(e * e));
        py = scale_round(a, longint'(root) * s, 61);
        cordic(el.peri, co, so);
        cordic(el.incl, ci, si);
        cordic(el.node, cn, sn);
        x1 = scale_round(px, co, 30) - scale_round(py, so, 30);
        y1 = scale_round(px, so, 30) + scale_round(py, co, 30);
        y2 = scale_round(y1, ci, 30);
        z2 = scale_round(y1, si, 30);
        r.x = clamp49(scale_round(x1, cn, 30) - scale_round(y2, sn, 30));
        r.y = clamp49(scale_round(x1, sn, 30) + scale_round(y2, cn, 30));
        r.z = clamp49(z2);
        r.not_conv = !done;
        return r;
    endfunction

    function automatic elements_t unpack_request();
        elements_t el;
        el.frame = s_axis_tuser;
        el.sma   = s_axis_tdata[46:0];
        el.ecc   = s_axis_tdata[77:47];
        el.incl  = s_axis_tdata[109:78];
        el.node  = s_axis_tdata[141:110];
        el.peri  = s_axis_tdata[173:142];
        el.mean  = s_axis_tdata[205:174];
        return el;
    endfunction

    function automatic elements_t random_elements();
        elements_t el;
        int        pick;
        el.frame = ($urandom_range(99) < 10) ? FRAME_EARTH_FIXED : 2'($urandom_range(3, 1));
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            el.sma = 47'($urandom_range(50000000, 6000000));
        end
        else if (pick < 90)
        begin
            el.sma = {15'($urandom), $urandom};
        end
        else
        begin
            el.sma = 47'($urandom_range(100));
        end
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            el.ecc = 31'($urandom_range(644245094));
        end
        else if (pick < 85)
        begin
            el.ecc = 31'($urandom);
        end
        else
        begin
            el.ecc = 31'h7FFFFFFF - 31'($urandom_range(1 << 20));
        end
        el.incl = $urandom;
        el.node = $urandom;
        el.peri = $urandom;
        el.mean = $urandom;
        return el;
    endfunction

    function automatic elements_t make_el(input logic [1:0] fr, input logic [46:0] a,
                                          input logic [30:0] e, input logic [31:0] i,
                                          input logic [31:0] n, input logic [31:0] w,
                                          input logic [31:0] m);
        elements_t el;
        el.frame = fr;
        el.sma = a;
        el.ecc = e;
        el.incl = i;
        el.node = n;
        el.peri = w;
        el.mean = m;
        return el;
    endfunction

    task automatic add_row(input elements_t el);
        directed_row_t row;
        row.el = el;
        row.fixed = (el.frame == FRAME_EARTH_FIXED);
        directed.push_back(row);
    endtask

    task automatic send_request(input elements_t el, input bit fixed);
        while (!calm && $urandom_range(99) < 23)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= el.frame;
        s_axis_tdata  <= {2'b00, el.mean, el.peri, el.node, el.incl, el.ecc, el.sma};
        cur_fixed     <= fixed;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_tolerance(input logic [15:0] tol);
        s_axis_tvalid <= 1'b0;
        while (expected_positions.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= tol;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        position_t exp_p;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                tol_model = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                requests_in++;
                if (cur_fixed)
                begin
                    exp_p = '{x: '0, y: '0, z: '0, frame: FRAME_EARTH_FIXED,
                              frame_err: 1'b1, not_conv: 1'b0};
                end
                else
                begin
                    exp_p = predict_position(unpack_request(), tol_model);
                end
                expected_positions.push_back(exp_p);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                positions_out++;
                unconverged_seen += m_axis_tuser[3];
                frame_errors_seen += m_axis_tuser[2];
                if (expected_positions.size() == 0)
                begin
                    $error("Unexpected position response");
                    errors++;
                end
                else
                begin
                    exp_p = expected_positions.pop_front();
                    check_field("pos_x", exp_p.x, m_axis_tdata[48:0]);
                    check_field("pos_y", exp_p.y, m_axis_tdata[97:49]);
                    check_field("pos_z", exp_p.z, m_axis_tdata[146:98]);
                    check_field("frame_out", exp_p.frame, m_axis_tuser[1:0]);
                    check_field("frame_error", exp_p.frame_err, m_axis_tuser[2]);
                    check_field("not_converged", exp_p.not_conv, m_axis_tuser[3]);
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
            begin
                idle_count = 0;
            end
            else
            begin
                idle_count++;
                if (idle_count >= STALL_LIMIT)
                begin
                    $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_request && hold_left == 0)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= calm || ($urandom_range(99) >= 23);
        end
    end

    initial
    begin
        logic [15:0] tolerances[5];
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        cur_fixed = 1'b0;
        calm = 1'b0;
        hold_request = 1'b0;
        hold_left = 0;
        errors = 0;
        requests_in = 0;
        positions_out = 0;
        unconverged_seen = 0;
        frame_errors_seen = 0;
        idle_count = 0;
        tol_model = 16'd684;

        add_row(make_el(FRAME_EARTH_FIXED, '1, '1, '1, '1, '1, '1));
        add_row(make_el(FRAME_EARTH_FIXED, '0, '0, '0, '0, '0, '0));
        add_row(make_el(2'd1, '0, '0, '0, '0, '0, '0));
        add_row(make_el(2'd2, '1, '0, '0, '0, '0, '0));
        add_row(make_el(2'd3, '1, '1, 32'h80000000, 32'h80000000, 32'h80000000,
                        32'h80000000));
        add_row(make_el(2'd1, '1, '1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        32'h7FFFFFFF));
        add_row(make_el(2'd1, 47'd42164000, 31'h7FFFFFFF, 0, 0, 0, 32'h00000001));
        add_row(make_el(2'd2, 47'd42164000, 31'h7FFFFF00, 32'h40000000, 0, 0, 0));
        add_row(make_el(2'd3, 47'd6778000, 31'd1073741824, 32'h40000000, 32'h40000000,
                        32'h40000000, 32'h40000000));
        add_row(make_el(2'd1, 47'd6778000, 31'd1073741824, 32'hC0000000, 32'hC0000000,
                        32'hC0000000, 32'hC0000000));
        add_row(make_el(2'd2, 47'd26560000, 31'd21474836, 32'h40000001, 32'hBFFFFFFF,
                        32'h3FFFFFFF, 32'hC0000001));
        add_row(make_el(2'd3, 47'h7FFFFFFFFFFF, 31'd2040109465, 32'h12345678,
                        32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0));
        add_row(make_el(2'd1, 47'h555555555555, 31'h2AAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                        32'h55555555, 32'hAAAAAAAA));
        add_row(make_el(2'd2, 47'h2AAAAAAAAAAA, 31'h55555555, 32'hAAAAAAAA, 32'h55555555,
                        32'hAAAAAAAA, 32'h55555555));
        add_row(make_el(2'd3, 47'd1, 31'd1, 32'd1, 32'd1, 32'd1, 32'd1));
        add_row(make_el(FRAME_EARTH_FIXED, 47'd6778000, 31'd1000, 32'h40000000, 0, 0, 0));

        tolerances = '{16'd1, 16'd65535, 16'd0, 16'd684, 16'($urandom_range(65535, 1))};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            send_request(directed[i].el, directed[i].fixed);
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            write_tolerance(tolerances[ph]);
            calm = (ph == 0);
            for (int k = 0; k < 57; k++)
            begin
                if (ph == 1 && k == 10)
                begin
                    hold_request = 1'b1;
                end
                send_request(random_elements(), 1'b0);
            end
            calm = 1'b0;
        end
        s_axis_tvalid <= 1'b0;

        while (expected_positions.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);

        $display("Covered %0d requests and %0d responses over six tolerance settings,",
                 requests_in, positions_out);
        $display("with %0d earth-fixed rejections and %0d unconverged solutions.",
                 frame_errors_seen, unconverged_seen);
        if (errors == 0 && expected_positions.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
